@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the bit-field buffer block.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/bfa_pkg.sv @@
// Shared types and constants for the bit-field buffer block.
// No dependencies.
`default_nettype none

package bfa_pkg;

	localparam int BUFFER_WORDS_DEF = 64;

	localparam int WORD_W  = 32;
	localparam int LEN_W   = 6;
	localparam int IDX_W   = 11;
	localparam int STAT_W  = 2;
	localparam int WIDX_W  = IDX_W - 5;
	localparam int WIN_W   = 2 * WORD_W;
	localparam int SH_W    = 7;

	// Operation codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_LEN = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
	} stat_t;

endpackage

`default_nettype wire

@@ src/bfa_ctrl.sv @@
// Controller for the bit-field buffer block: clearing pass, accept, execute.
// Depends on bfa_pkg.
`default_nettype none

module bfa_ctrl
	import bfa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   ready_c;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && ready_c) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Outputs: take a transfer only when the result register will be free
	always_comb begin
		ready_c    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.accept = in_valid && ready_c;
		cmd.exec   = (state_q == ST_EXEC);
	end

	assign in_ready  = ready_c;
	assign out_valid = out_valid_q;

	// Hold state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/bfa_datapath.sv @@
// Datapath for the bit-field buffer block: even/odd word banks, checks,
// field extract and merge, result register. Depends on bfa_pkg.
`default_nettype none

module bfa_datapath
	import bfa_pkg::*;
#(
	parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	input  wire logic              op,
	input  wire logic [LEN_W-1:0]  field_length,
	input  wire logic [IDX_W-1:0]  bit_index,
	input  wire logic [WORD_W-1:0] write_value,
	output logic      [WORD_W-1:0] read_value,
	output logic      [STAT_W-1:0] status
);

	localparam int EVEN_DEPTH = (BUFFER_WORDS + 1) / 2;
	localparam int ODD_DEPTH  = BUFFER_WORDS / 2;
	localparam int ADDR_W     = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
	localparam int WIDE_W     = (ADDR_W > WIDX_W) ? ADDR_W : WIDX_W;
	localparam int TOTAL_BITS = WORD_W * BUFFER_WORDS;

	logic [WORD_W-1:0] ev_mem [EVEN_DEPTH];
	logic [WORD_W-1:0] od_mem [ODD_DEPTH];

	// Input side decode
	logic [WIDX_W-1:0] word_idx;
	logic [4:0]        off;
	logic [WIDE_W-1:0] ev_full, od_full;
	logic [ADDR_W-1:0] ev_addr, od_addr;
	logic [IDX_W:0]    end_bit;
	logic [STAT_W-1:0] status_c;
	logic              spans_c;

	always_comb begin
		word_idx = bit_index[IDX_W-1:5];
		off      = bit_index[4:0];
		ev_full  = WIDE_W'(word_idx >> 1) + WIDE_W'(word_idx[0]);
		od_full  = WIDE_W'(word_idx >> 1);
		ev_addr  = ev_full[ADDR_W-1:0];
		od_addr  = od_full[ADDR_W-1:0];
		end_bit  = {1'b0, bit_index} + (IDX_W + 1)'(field_length);
		spans_c  = (SH_W'(off) + SH_W'(field_length)) > SH_W'(WORD_W);
		if (field_length == '0 || field_length > LEN_W'(WORD_W)) begin
			status_c = STAT_BAD_LEN;
		end else if (32'(end_bit) > TOTAL_BITS) begin
			status_c = STAT_RANGE;
		end else begin
			status_c = STAT_OK;
		end
	end

	// Latch the item on transfer
	logic              op_s1, odd_s1, spans_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [4:0]        off_s1;
	logic [WORD_W-1:0] wval_s1;
	logic [STAT_W-1:0] status_s1;
	logic [ADDR_W-1:0] ev_addr_s1, od_addr_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1      <= op;
			odd_s1     <= word_idx[0];
			spans_s1   <= spans_c;
			len_s1     <= field_length;
			off_s1     <= off;
			wval_s1    <= write_value;
			status_s1  <= status_c;
			ev_addr_s1 <= ev_addr;
			od_addr_s1 <= od_addr;
		end
	end

	// Clearing pass counter
	logic [ADDR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign stat.clear_last = (clr_q == ADDR_W'(EVEN_DEPTH - 1));

	// Extract and merge on the window of two words
	logic [WORD_W-1:0] ev_rd_q, od_rd_q;
	logic [WORD_W-1:0] word_a, word_b;
	logic [WIN_W-1:0]  window, mask, merged;
	logic [SH_W-1:0]   sh;
	logic [WIN_W-1:0]  field;
	logic              do_write;

	always_comb begin
		word_a   = odd_s1 ? od_rd_q : ev_rd_q;
		word_b   = spans_s1 ? (odd_s1 ? ev_rd_q : od_rd_q) : '0;
		window   = {word_a, word_b};
		sh       = SH_W'(WIN_W) - SH_W'(off_s1) - SH_W'(len_s1);
		mask     = (WIN_W'(1) << len_s1) - WIN_W'(1);
		field    = (window >> sh) & mask;
		merged   = (window & ~(mask << sh)) | ((WIN_W'(wval_s1) & mask) << sh);
		do_write = cmd.exec && (op_s1 == OP_WRITE) && (status_s1 == STAT_OK);
	end

	// Bank write ports: clearing pass or write-back
	logic              ev_we, od_we;
	logic [ADDR_W-1:0] ev_wa, od_wa;
	logic [WORD_W-1:0] ev_wd, od_wd;

	always_comb begin
		if (cmd.clear) begin
			ev_we = 1'b1;
			od_we = 32'(clr_q) < ODD_DEPTH;
			ev_wa = clr_q;
			od_wa = clr_q;
			ev_wd = '0;
			od_wd = '0;
		end else begin
			ev_we = do_write && (!odd_s1 || spans_s1);
			od_we = do_write && (odd_s1 || spans_s1);
			ev_wa = ev_addr_s1;
			od_wa = od_addr_s1;
			ev_wd = odd_s1 ? merged[WORD_W-1:0] : merged[WIN_W-1:WORD_W];
			od_wd = odd_s1 ? merged[WIN_W-1:WORD_W] : merged[WORD_W-1:0];
		end
	end

	// Banks: read on transfer, write on clear or write-back
	always_ff @(posedge clk) begin
		if (ev_we) ev_mem[ev_wa] <= ev_wd;
		if (cmd.accept) ev_rd_q <= ev_mem[ev_addr];
	end

	always_ff @(posedge clk) begin
		if (od_we) od_mem[od_wa] <= od_wd;
		if (cmd.accept) od_rd_q <= od_mem[od_addr];
	end

	// Result register
	logic [WORD_W-1:0] read_value_q;
	logic [STAT_W-1:0] status_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_s1;
			if (op_s1 == OP_READ && status_s1 == STAT_OK) begin
				read_value_q <= field[WORD_W-1:0];
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

`default_nettype wire

@@ src/bit_field_buffer_access.sv @@
// Bit-field read/write access to a word buffer whose bit 0 is the MSb of word 0.
// After reset the buffer is cleared, one even and one odd word per cycle, while no
// item is taken. For each item the transfer cycle reads the even and odd banks;
// the next cycle extracts or merges the field, writes back the one or two words
// that a write touches and loads the result register. No new item is taken until
// that execute step is over, so a bank read never overtakes a pending write-back.
// A finished result waits in an output register; no new item is taken while it
// waits, except in the cycle in which the result itself is transferred out.
`default_nettype none
`include "assert_macros.svh"

module bit_field_buffer_access
	import bfa_pkg::*;
#(
	parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic [LEN_W-1:0]  field_length,
	input  wire logic [IDX_W-1:0]  bit_index,
	input  wire logic [WORD_W-1:0] write_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [WORD_W-1:0] read_value,
	output logic      [STAT_W-1:0] status
);

	cmd_t  cmd;
	stat_t stat;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bfa_datapath #(
		.BUFFER_WORDS (BUFFER_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.field_length (field_length),
		.bit_index    (bit_index),
		.write_value  (write_value),
		.read_value   (read_value),
		.status       (status)
	);

	// Checks
	`ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_NEXT(a_result_follows, clk, arst_n, cmd.exec, out_valid)
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid, status != 2'd3)
	`ASSERT_IMPLIES(a_error_zero, clk, arst_n, out_valid && status != STAT_OK, read_value == '0)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for bit_field_buffer_access: field reads and writes on the word buffer.
// Holds its own copy of the buffer to predict each result; depends on bfa_pkg and the RTL.
`default_nettype none

// Mirror of the buffer plus the queue of results still owed by the block
class field_scoreboard;

	typedef struct {
		logic [bfa_pkg::WORD_W-1:0] value;
		logic [bfa_pkg::STAT_W-1:0] code;
	} field_result_t;

	localparam int TOTAL_BITS = bfa_pkg::BUFFER_WORDS_DEF * bfa_pkg::WORD_W;

	bit [bfa_pkg::WORD_W-1:0] words [bfa_pkg::BUFFER_WORDS_DEF];
	field_result_t due_q [$];
	int mismatches;

	// Work out the result of one accepted transfer and update the mirror
	function void note_transfer(bit op, bit [bfa_pkg::LEN_W-1:0] len,
			bit [bfa_pkg::IDX_W-1:0] idx, bit [bfa_pkg::WORD_W-1:0] wv);
		field_result_t r;
		bit [bfa_pkg::WIN_W-1:0] window;
		bit [bfa_pkg::WIN_W-1:0] mask;
		int unsigned w;
		int unsigned off;
		int unsigned sh;
		bit spans;
		r.value = '0;
		r.code = bfa_pkg::STAT_OK;
		if (len == 0 || len > bfa_pkg::WORD_W) begin
			r.code = bfa_pkg::STAT_BAD_LEN;
		end else if (int'(idx) + int'(len) > TOTAL_BITS) begin
			r.code = bfa_pkg::STAT_RANGE;
		end else begin
			w = idx >> 5;
			off = idx & 31;
			spans = (off + len) > bfa_pkg::WORD_W;
			// word w in the upper half, the next word below it when the field crosses over
			window = {words[w], spans ? words[w + 1] : 32'h0};
			sh = bfa_pkg::WIN_W - off - len;
			mask = (64'd1 << len) - 64'd1;
			if (op == bfa_pkg::OP_READ) begin
				r.value = 32'((window >> sh) & mask);
			end else begin
				window = (window & ~(mask << sh)) | ((64'(wv) & mask) << sh);
				words[w] = window[63:32];
				if (spans) begin
					words[w + 1] = window[31:0];
				end
			end
		end
		due_q.push_back(r);
	endfunction

	// Compare one result from the block with the oldest one owed
	function void check_result(logic [bfa_pkg::WORD_W-1:0] rv, logic [bfa_pkg::STAT_W-1:0] st);
		field_result_t e;
		if (due_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: result with none owed: read_value %h status %0d", $time, rv, st);
			end
			return;
		end
		e = due_q.pop_front();
		if (rv !== e.value || st !== e.code) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch: read_value exp %h got %h, status exp %0d got %0d",
					$time, e.value, rv, e.code, st);
			end
		end
	endfunction

	function int owed();
		return due_q.size();
	endfunction

endclass

module tb_top;
	import bfa_pkg::*;

	localparam int TOTAL_BITS = BUFFER_WORDS_DEF * WORD_W;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              op;
	logic [LEN_W-1:0]  field_length;
	logic [IDX_W-1:0]  bit_index;
	logic [WORD_W-1:0] write_value;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] read_value;
	logic [STAT_W-1:0] status;

	// both sides stop idling while set
	bit no_idle;
	// asks the receiver for one long hold-off
	bit hold_req;

	field_scoreboard sb;

	bit_field_buffer_access dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.field_length (field_length),
		.bit_index    (bit_index),
		.write_value  (write_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_value   (read_value),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#7_200_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Drop valid ahead of the next transfer when n is above zero
	task automatic idle_sender(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Offer one item after a random gap and hold it until the transfer
	task automatic offer_field(bit o, bit [LEN_W-1:0] n, bit [IDX_W-1:0] ix, bit [WORD_W-1:0] v);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = 0;
		if (!no_idle) begin
			if (r >= 92) begin
				gap = $urandom_range(10, 30);
			end else if (r >= 60) begin
				gap = $urandom_range(1, 3);
			end
		end
		idle_sender(gap);
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		field_length <= n;
		bit_index <= ix;
		write_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_transfer(o, n, ix, v);
	endtask

	// Draw a random item: mostly in-range fields, some bad lengths and overruns
	task automatic offer_random();
		bit o;
		bit [LEN_W-1:0] n;
		bit [IDX_W-1:0] ix;
		bit [WORD_W-1:0] v;
		int r;
		int k;
		r = $urandom_range(0, 99);
		o = 1'($urandom_range(0, 1));
		v = $urandom;
		if (r < 6) begin
			n = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
			ix = 11'($urandom);
		end else if (r < 12) begin
			n = 6'($urandom_range(2, 32));
			ix = 11'($urandom_range(TOTAL_BITS - n + 1, TOTAL_BITS - 1));
		end else if (r < 17) begin
			n = 6'($urandom);
			ix = 11'($urandom);
		end else begin
			k = $urandom_range(0, 9);
			n = (k == 0) ? 6'd1 : (k == 1) ? 6'd32 : 6'($urandom_range(1, 32));
			ix = 11'($urandom_range(0, TOTAL_BITS - n));
		end
		offer_field(o, n, ix, v);
	endtask

	// Take results, stalling at random or on request
	initial begin : receiver
		int stall_left;
		int r;
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(read_value, status);
			end
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 250;
				out_ready <= 1'b0;
			end else if (no_idle || r < 70) begin
				out_ready <= 1'b1;
			end else if (r < 95) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				stall_left = $urandom_range(10, 30);
				out_ready <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		sb = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_READ;
		field_length = '0;
		bit_index = '0;
		write_value = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// whole first word, cleared then set
		offer_field(OP_READ, 6'd32, 11'd0, 32'hDEAD_BEEF);
		offer_field(OP_WRITE, 6'd32, 11'd0, 32'hFFFF_FFFF);
		offer_field(OP_READ, 6'd32, 11'd0, 32'h0);
		// last bit and last whole word
		offer_field(OP_WRITE, 6'd1, 11'd2047, 32'h0000_0001);
		offer_field(OP_READ, 6'd1, 11'd2047, 32'h0);
		offer_field(OP_WRITE, 6'd32, 11'd2016, 32'hA5A5_5A5A);
		offer_field(OP_READ, 6'd32, 11'd2016, 32'h0);
		// fields running one bit past the end
		offer_field(OP_READ, 6'd32, 11'd2017, 32'h0);
		offer_field(OP_WRITE, 6'd2, 11'd2047, 32'hFFFF_FFFF);
		// bad lengths, checked ahead of the range
		offer_field(OP_READ, 6'd0, 11'd5, 32'h0);
		offer_field(OP_WRITE, 6'd33, 11'd0, 32'h0);
		offer_field(OP_WRITE, 6'd63, 11'd2047, 32'hFFFF_FFFF);
		offer_field(OP_READ, 6'd32, 11'd0, 32'h0);
		// field crossing a word boundary
		offer_field(OP_WRITE, 6'd32, 11'd20, 32'h1234_5678);
		offer_field(OP_READ, 6'd32, 11'd20, 32'h0);
		offer_field(OP_READ, 6'd5, 11'd30, 32'h0);
		offer_field(OP_WRITE, 6'd2, 11'd31, 32'h0000_0002);
		offer_field(OP_READ, 6'd2, 11'd31, 32'h0);
		// upper bits of the value must be ignored
		offer_field(OP_WRITE, 6'd4, 11'd100, 32'hFFFF_FFF5);
		offer_field(OP_READ, 6'd12, 11'd96, 32'h0);
		offer_field(OP_WRITE, 6'd17, 11'd1020, 32'h7FFF_FFFF);
		offer_field(OP_READ, 6'd17, 11'd1020, 32'h0);
		offer_field(OP_READ, 6'd32, 11'd1008, 32'h0);

		// normal idling on both sides
		repeat (600) offer_random();

		// let the block drain completely
		idle_sender(1);
		while (sb.owed() != 0) @(posedge clk);

		// back-to-back stretch
		no_idle = 1'b1;
		repeat (300) offer_random();
		no_idle = 1'b0;

		// long hold-off on the result side while items keep coming
		hold_req = 1'b1;
		repeat (400) offer_random();

		repeat (600) offer_random();

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.owed() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/bfa_pkg.sv
src/bfa_ctrl.sv
src/bfa_datapath.sv
src/bit_field_buffer_access.sv
tb/tb_top.sv
